>>> rtl/vn3_pkg.sv
`timescale 1ns / 1ps

package vn3_pkg;

    typedef enum logic [1:0] {
        KIND_SCR = 2'd0,
        KIND_LAT = 2'd1,
        KIND_Q3D = 2'd2,
        KIND_Q1D = 2'd3
    } kind_t;

    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;
    localparam int VAL_W   = 16;
    localparam int SCR_W   = 8;
    localparam int ADDR_W  = 8;
    localparam int OUT_W   = 17;
    localparam int CORNERS = 8;

    localparam logic [15:0] LATTICE_OFFSET = 16'd10000;
    localparam logic [17:0] SMOOTH_THREE   = 18'd196608;
    localparam logic signed [17:0] ONE_Q15 = 18'sd32768;
    localparam logic signed [17:0] OUT_MAX = 18'sd65535;

    // smoothstep weight 3f^2 - 2f^3 from f*f and f, Q0.16
    function automatic logic [FRAC_W-1:0] smooth(input logic [31:0] ff,
                                                 input logic [FRAC_W-1:0] f);
        logic [17:0] w;
        logic [49:0] p;
        begin
            w = SMOOTH_THREE - {1'b0, f, 1'b0};
            p = 50'(ff) * 50'(w);
            return p[47:32];
        end
    endfunction

    // floor((a*(1-s) + b*s)) as a + floor((b-a)*s)
    function automatic logic signed [VAL_W-1:0] lerp(input logic signed [VAL_W-1:0] a,
                                                     input logic signed [VAL_W-1:0] b,
                                                     input logic [FRAC_W-1:0] s);
        logic signed [16:0] d;
        logic signed [16:0] sw;
        logic signed [33:0] p;
        logic signed [17:0] r;
        logic signed [17:0] t;
        begin
            d  = 17'({b[15], b}) - 17'({a[15], a});
            sw = $signed({1'b0, s});
            p  = d * sw;
            r  = p[33:16];
            t  = r + $signed({{2{a[15]}}, a});
            return t[15:0];
        end
    endfunction

endpackage

>>> rtl/vn3_ram.sv
`timescale 1ns / 1ps

module vn3_ram #(
    parameter int AW = 8,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/vn3_axis.sv
`timescale 1ns / 1ps

module vn3_axis #(
    parameter int IDX_W = 8
) (
    input  logic [vn3_pkg::COORD_W-1:0] coord,
    output logic [IDX_W-1:0]            lo,
    output logic [IDX_W-1:0]            hi,
    output logic [vn3_pkg::FRAC_W-1:0]  frac
);

    logic [15:0] ip;

    // floor of the integer part plus offset; only the masked bits matter
    assign ip   = coord[31:16] + vn3_pkg::LATTICE_OFFSET;
    assign lo   = ip[IDX_W-1:0];
    assign hi   = lo + IDX_W'(1);
    assign frac = coord[15:0];

endmodule

>>> rtl/value_noise_3d_trilinear_top.sv
`timescale 1ns / 1ps

// lattice value noise, 3d trilinear and 1d, fixed point
// input channel: in_valid / in_stall with fields kind, table_addr, scramble_value,
//   noise_value, x_coord, y_coord, z_coord; kind selects a scramble load, a lattice
//   load, a 3d query or a 1d query
// output channel: out_valid / out_stall with noise_out, one transfer per query,
//   none per load
// a query passes through stages 1 to 6 and then the output register, which drives
//   out_valid
// throughput: one item per cycle while out_stall does not hold the output, set by the
//   seven-stage pipeline; the tables are replicated into eight single-read copies so all cell corners are read at once
// loads write the tables at the pipeline stage where queries read them, so items
//   see the tables in the order they were accepted
// tables are undefined after reset; reading an unwritten entry gives garbage
// reset clears the stage valid bits only
// when out_stall holds a result, bubbles still collapse and the input keeps
//   taking items until every stage is full; in_stall then rises

module value_noise_3d_trilinear_top #(
    parameter int TABLE_SIZE = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         kind,
    input  logic [vn3_pkg::ADDR_W-1:0]         table_addr,
    input  logic [vn3_pkg::SCR_W-1:0]          scramble_value,
    input  logic signed [vn3_pkg::VAL_W-1:0]   noise_value,
    input  logic signed [vn3_pkg::COORD_W-1:0] x_coord,
    input  logic signed [vn3_pkg::COORD_W-1:0] y_coord,
    input  logic signed [vn3_pkg::COORD_W-1:0] z_coord,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [vn3_pkg::OUT_W-1:0]   noise_out
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int NC    = vn3_pkg::CORNERS;
    localparam int FW    = vn3_pkg::FRAC_W;
    localparam int VW    = vn3_pkg::VAL_W;

    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_out;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, out_vld_reg;

    // stage 1: input register
    vn3_pkg::kind_t                    k1_reg;
    logic [vn3_pkg::ADDR_W-1:0]        a1_reg;
    logic [vn3_pkg::SCR_W-1:0]         sv1_reg;
    logic signed [VW-1:0]              nv1_reg;
    logic [vn3_pkg::COORD_W-1:0]       x1_reg, y1_reg, z1_reg;

    // stage 2: corners and f*f
    vn3_pkg::kind_t                    k2_reg;
    logic [IDX_W-1:0]                  a2_reg;
    logic [vn3_pkg::SCR_W-1:0]         sv2_reg;
    logic signed [VW-1:0]              nv2_reg;
    logic [IDX_W-1:0]                  xl2_reg, xh2_reg, yl2_reg, yh2_reg, zl2_reg, zh2_reg;
    logic [FW-1:0]                     fx2_reg, fy2_reg, fz2_reg;
    logic [31:0]                       ffx2_reg, ffy2_reg, ffz2_reg;

    // stage 3: scramble data, weights
    vn3_pkg::kind_t                    k3_reg;
    logic [IDX_W-1:0]                  a3_reg;
    logic signed [VW-1:0]              nv3_reg;
    logic [FW-1:0]                     sx3_reg, sy3_reg, sz3_reg;

    // stage 4: lattice data
    vn3_pkg::kind_t                    k4_reg;
    logic [FW-1:0]                     sx4_reg, sy4_reg, sz4_reg;

    // stage 5 and 6: blends
    vn3_pkg::kind_t                    k5_reg, k6_reg, kout_reg;
    logic [FW-1:0]                     sx5_reg, sy5_reg, sx6_reg;
    logic signed [VW-1:0]              b5_reg [4];
    logic signed [VW-1:0]              e6_reg [2];
    logic signed [vn3_pkg::OUT_W-1:0]  noise_reg;

    logic [IDX_W-1:0]                  xl, xh, yl, yh, zl, zh;
    logic [FW-1:0]                     fx, fy, fz;
    logic                              is_1d;
    logic [IDX_W-1:0]                  hash [NC];
    logic [vn3_pkg::SCR_W-1:0]         scr_data [NC];
    logic [VW-1:0]                     lat_data [NC];
    logic                              scr_we, lat_we;
    logic signed [VW-1:0]              xv;
    logic signed [17:0]                inv;
    logic signed [vn3_pkg::OUT_W-1:0]  noise_next;

    assign rdy_out  = !out_vld_reg || !out_stall;
    assign rdy6     = !v6_reg || rdy_out;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            // loads end here, only queries go on
            if (rdy4)
            begin
                v4_reg <= v3_reg && (k3_reg == vn3_pkg::KIND_Q3D || k3_reg == vn3_pkg::KIND_Q1D);
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
            if (rdy6)
            begin
                v6_reg <= v5_reg;
            end
            if (rdy_out)
            begin
                out_vld_reg <= v6_reg;
            end
        end
    end

    vn3_axis #(.IDX_W(IDX_W)) u_axis_x (.coord(x1_reg), .lo(xl), .hi(xh), .frac(fx));
    vn3_axis #(.IDX_W(IDX_W)) u_axis_y (.coord(y1_reg), .lo(yl), .hi(yh), .frac(fy));
    vn3_axis #(.IDX_W(IDX_W)) u_axis_z (.coord(z1_reg), .lo(zl), .hi(zh), .frac(fz));

    assign is_1d = (k1_reg == vn3_pkg::KIND_Q1D);

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            k1_reg  <= vn3_pkg::kind_t'(kind);
            a1_reg  <= table_addr;
            sv1_reg <= scramble_value;
            nv1_reg <= noise_value;
            x1_reg  <= x_coord;
            y1_reg  <= y_coord;
            z1_reg  <= z_coord;
        end
        if (rdy2)
        begin
            k2_reg  <= k1_reg;
            a2_reg  <= IDX_W'(a1_reg);
            sv2_reg <= sv1_reg;
            nv2_reg <= nv1_reg;
            // 1d: x and y collapse to corner zero with zero weight
            xl2_reg  <= is_1d ? '0 : xl;
            xh2_reg  <= is_1d ? '0 : xh;
            yl2_reg  <= is_1d ? '0 : yl;
            yh2_reg  <= is_1d ? '0 : yh;
            zl2_reg  <= zl;
            zh2_reg  <= zh;
            fx2_reg  <= is_1d ? '0 : fx;
            fy2_reg  <= is_1d ? '0 : fy;
            fz2_reg  <= fz;
            ffx2_reg <= is_1d ? '0 : 32'(fx) * 32'(fx);
            ffy2_reg <= is_1d ? '0 : 32'(fy) * 32'(fy);
            ffz2_reg <= 32'(fz) * 32'(fz);
        end
        if (rdy3)
        begin
            k3_reg  <= k2_reg;
            a3_reg  <= a2_reg;
            nv3_reg <= nv2_reg;
            sx3_reg <= vn3_pkg::smooth(ffx2_reg, fx2_reg);
            sy3_reg <= vn3_pkg::smooth(ffy2_reg, fy2_reg);
            sz3_reg <= vn3_pkg::smooth(ffz2_reg, fz2_reg);
        end
        if (rdy4)
        begin
            k4_reg  <= k3_reg;
            sx4_reg <= sx3_reg;
            sy4_reg <= sy3_reg;
            sz4_reg <= sz3_reg;
        end
        if (rdy5)
        begin
            k5_reg    <= k4_reg;
            sx5_reg   <= sx4_reg;
            sy5_reg   <= sy4_reg;
            b5_reg[0] <= vn3_pkg::lerp(lat_data[0], lat_data[1], sz4_reg);
            b5_reg[1] <= vn3_pkg::lerp(lat_data[2], lat_data[3], sz4_reg);
            b5_reg[2] <= vn3_pkg::lerp(lat_data[4], lat_data[5], sz4_reg);
            b5_reg[3] <= vn3_pkg::lerp(lat_data[6], lat_data[7], sz4_reg);
        end
        if (rdy6)
        begin
            k6_reg    <= k5_reg;
            sx6_reg   <= sx5_reg;
            e6_reg[0] <= vn3_pkg::lerp(b5_reg[0], b5_reg[1], sy5_reg);
            e6_reg[1] <= vn3_pkg::lerp(b5_reg[2], b5_reg[3], sy5_reg);
        end
        if (rdy_out)
        begin
            kout_reg  <= k6_reg;
            noise_reg <= noise_next;
        end
    end

    assign scr_we = rdy3 && v2_reg && (k2_reg == vn3_pkg::KIND_SCR);
    assign lat_we = rdy4 && v3_reg && (k3_reg == vn3_pkg::KIND_LAT);

    // corner index bits are {x, y, z}
    genvar c;
    generate
        for (c = 0; c < NC; c++)
        begin : g_corner
            assign hash[c] = ((((c >> 2) & 1) != 0) ? xh2_reg : xl2_reg)
                           ^ ((((c >> 1) & 1) != 0) ? yh2_reg : yl2_reg)
                           ^ (((c & 1) != 0) ? zh2_reg : zl2_reg);

            vn3_ram #(.AW(IDX_W), .DW(vn3_pkg::SCR_W)) u_scr (
                .clk   (clk),
                .we    (scr_we),
                .waddr (a2_reg),
                .wdata (sv2_reg),
                .re    (rdy3),
                .raddr (hash[c]),
                .rdata (scr_data[c])
            );

            vn3_ram #(.AW(IDX_W), .DW(VW)) u_lat (
                .clk   (clk),
                .we    (lat_we),
                .waddr (a3_reg),
                .wdata (nv3_reg),
                .re    (rdy4),
                .raddr (IDX_W'(scr_data[c])),
                .rdata (lat_data[c])
            );
        end
    endgenerate

    always_comb
    begin
        xv  = vn3_pkg::lerp(e6_reg[0], e6_reg[1], sx6_reg);
        inv = vn3_pkg::ONE_Q15 - $signed({{2{xv[15]}}, xv});
        if (k6_reg == vn3_pkg::KIND_Q1D)
        begin
            noise_next = (inv > vn3_pkg::OUT_MAX) ? vn3_pkg::OUT_W'(vn3_pkg::OUT_MAX)
                                                  : vn3_pkg::OUT_W'(inv);
        end
        else
        begin
            noise_next = $signed({xv[15], xv});
        end
    end

    assign out_valid = out_vld_reg;
    assign noise_out = noise_reg;

    a_no_load_past_tables: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (k4_reg == vn3_pkg::KIND_Q3D || k4_reg == vn3_pkg::KIND_Q1D))
        else $error("load item reached blend stages");

    a_1d_positive: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && kout_reg == vn3_pkg::KIND_Q1D |-> !noise_reg[vn3_pkg::OUT_W-1])
        else $error("1d result negative");

    a_full_pipe_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_stall && v6_reg && v5_reg && v4_reg && v3_reg && v2_reg && v1_reg
        |-> in_stall)
        else $error("input taken while pipeline full and stalled");

    a_stage6_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v6_reg && out_vld_reg && out_stall |=> v6_reg && $stable(e6_reg[0]))
        else $error("stage 6 lost data under stall");

endmodule
